FILE: rtl/row_fir_filter_clamp_core_defines.svh
// assertion helpers for the row filter core
// both expect aclk and aresetn in the scope of the use
`ifndef ROW_FIR_FILTER_CLAMP_CORE_DEFINES_SVH
`define ROW_FIR_FILTER_CLAMP_CORE_DEFINES_SVH

// same-cycle implication
`define RFFC_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define RFFC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/rffc_pkg.sv
package rffc_pkg;

    localparam int PIX_W              = 8;
    localparam int COEF_W             = 16;
    localparam int PROD_W             = PIX_W + COEF_W;
    localparam int LAG_W              = 3;
    localparam int COEF_FRAC_BITS     = 14;
    localparam int COEF_TAPS_SIDE     = 4;
    localparam int DEFAULT_MAX_RADIUS = 4;
    localparam int CFG_DATA_W         = 64;
    localparam int CFG_INDEX_W        = 2;

    localparam logic [PIX_W-1:0]  PIX_MAX           = 8'hFF;
    localparam logic [LAG_W-1:0]  SEEN_MAX          = 3'd7;
    localparam logic [COEF_W-1:0] COEF_CENTER_RESET = 16'h4000;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_COEF_LEFT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COEF_RIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COEF_CENTER = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS      = 2'd3;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] coef_left;
        logic [CFG_DATA_W-1:0] coef_right;
        logic [COEF_W-1:0]     coef_center;
        logic [LAG_W-1:0]      radius;
    } cfg_t;

    typedef struct packed {
        logic row_last;
        logic burst_last;
    } res_flags_t;

    // one column request from the window stage to the arithmetic
    typedef struct packed {
        logic             valid;
        logic [LAG_W-1:0] lag;
        logic [LAG_W-1:0] radius;
        res_flags_t       flags;
    } tap_req_t;

    // coefficient of tap offset j, zero beyond the stored taps
    function automatic logic signed [COEF_W-1:0] tap_coef(input cfg_t cfg, input int j);
        int                    k;
        logic [CFG_DATA_W-1:0] bank;
        k    = (j < 0) ? -j : j;
        bank = (j < 0) ? cfg.coef_left : cfg.coef_right;
        if (j == 0) begin
            return $signed(cfg.coef_center);
        end
        if (k > COEF_TAPS_SIDE) begin
            return '0;
        end
        return $signed(bank[COEF_W*(k-1) +: COEF_W]);
    endfunction

endpackage

FILE: rtl/rffc_cfg.sv
module rffc_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rffc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rffc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output rffc_pkg::cfg_t                      cfg
);
    import rffc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_COEF_LEFT:   cfg_next.coef_left   = cfg_wdata;
                CFG_COEF_RIGHT:  cfg_next.coef_right  = cfg_wdata;
                CFG_COEF_CENTER: cfg_next.coef_center = cfg_wdata[COEF_W-1:0];
                CFG_RADIUS:      cfg_next.radius      = cfg_wdata[LAG_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coef_left   <= '0;
            cfg_reg.coef_right  <= '0;
            cfg_reg.coef_center <= COEF_CENTER_RESET;
            cfg_reg.radius      <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/rffc_window.sv
module rffc_window #(
    parameter int MAX_RADIUS = rffc_pkg::DEFAULT_MAX_RADIUS
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [rffc_pkg::PIX_W-1:0]              s_pixel,
    input  logic                                    s_row_end,
    input  logic [rffc_pkg::LAG_W-1:0]              cfg_radius,
    input  logic                                    tap_ready,
    output rffc_pkg::tap_req_t                      tap_req,
    output logic [2*MAX_RADIUS:0][rffc_pkg::PIX_W-1:0] window
);
    import rffc_pkg::*;

    localparam int WIN_LEN = 2 * MAX_RADIUS + 1;

    logic [WIN_LEN-1:0][PIX_W-1:0] window_reg, window_next;
    logic [LAG_W-1:0] seen_reg, seen_next;
    logic             valid_reg, valid_next;
    logic             flush_reg, flush_next;
    logic [LAG_W-1:0] lag_reg, lag_next;
    logic [LAG_W-1:0] radius_reg, radius_next;
    logic [LAG_W-1:0] r_eff;
    logic             accept;
    logic             job_done;

    assign r_eff    = (int'(cfg_radius) > MAX_RADIUS) ? LAG_W'(MAX_RADIUS) : cfg_radius;
    assign job_done = valid_reg && tap_ready && (!flush_reg || (lag_reg == '0));
    assign s_ready  = !valid_reg || job_done;
    assign accept   = s_valid && s_ready;

    always_comb begin
        window_next = window_reg;
        seen_next   = seen_reg;
        valid_next  = valid_reg;
        flush_next  = flush_reg;
        lag_next    = lag_reg;
        radius_next = radius_reg;
        if (accept) begin
            // first pixel of a row fills the window: left edge replication
            if (seen_reg == '0) begin
                for (int i = 0; i < WIN_LEN; i++) begin
                    window_next[i] = s_pixel;
                end
            end else begin
                window_next = {window_reg[WIN_LEN-2:0], s_pixel};
            end
            radius_next = r_eff;
            if (!s_row_end) begin
                valid_next = (seen_reg >= r_eff);
                flush_next = 1'b0;
                lag_next   = r_eff;
                seen_next  = (seen_reg != SEEN_MAX) ? seen_reg + 1'b1 : seen_reg;
            end else begin
                valid_next = 1'b1;
                flush_next = 1'b1;
                lag_next   = (seen_reg < r_eff) ? seen_reg : r_eff;
                seen_next  = '0;
            end
        end else if (valid_reg && tap_ready) begin
            if (flush_reg && (lag_reg != '0)) begin
                lag_next = lag_reg - 1'b1;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            seen_reg  <= seen_next;
            valid_reg <= valid_next;
        end
        window_reg <= window_next;
        flush_reg  <= flush_next;
        lag_reg    <= lag_next;
        radius_reg <= radius_next;
    end

    assign tap_req.valid            = valid_reg;
    assign tap_req.lag              = lag_reg;
    assign tap_req.radius           = radius_reg;
    assign tap_req.flags.row_last   = flush_reg && (lag_reg == '0);
    assign tap_req.flags.burst_last = !flush_reg || (lag_reg == '0);
    assign window                   = window_reg;

endmodule

FILE: rtl/rffc_mac.sv
module rffc_mac #(
    parameter int MAX_RADIUS = rffc_pkg::DEFAULT_MAX_RADIUS
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  rffc_pkg::cfg_t                             cfg,
    input  rffc_pkg::tap_req_t                         tap_req,
    input  logic [2*MAX_RADIUS:0][rffc_pkg::PIX_W-1:0] window,
    output logic                                       tap_ready,
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic [rffc_pkg::PIX_W-1:0]                 m_filtered,
    output logic                                       m_row_last,
    output logic                                       m_burst_last
);
    import rffc_pkg::*;

    localparam int WIN_LEN = 2 * MAX_RADIUS + 1;
    localparam int IDX_W   = $clog2(WIN_LEN);
    localparam int SUM_W   = PROD_W + $clog2(WIN_LEN);

    logic signed [PROD_W-1:0] prod_next [WIN_LEN];
    logic signed [PROD_W-1:0] prod_reg  [WIN_LEN];
    logic                     prod_valid_reg;
    res_flags_t               prod_flags_reg;

    logic signed [SUM_W-1:0]  sum_next, sum_reg;
    logic                     sum_valid_reg;
    res_flags_t               sum_flags_reg;

    logic [PIX_W-1:0]         out_next, out_reg;
    logic                     out_valid_reg;
    res_flags_t               out_flags_reg;

    logic out_rdy, sum_rdy, prod_rdy;

    assign out_rdy   = !out_valid_reg || m_ready;
    assign sum_rdy   = !sum_valid_reg || out_rdy;
    assign prod_rdy  = !prod_valid_reg || sum_rdy;
    assign tap_ready = prod_rdy;

    // one product per tap; positions past the row ends clamp onto the window ends
    always_comb begin
        int                       j;
        int                       d;
        int                       k;
        logic [PIX_W-1:0]         pix;
        logic signed [COEF_W-1:0] coef;
        for (int t = 0; t < WIN_LEN; t++) begin
            j = t - MAX_RADIUS;
            d = int'(tap_req.lag) - j;
            k = (j < 0) ? -j : j;
            if (d < 0) begin
                d = 0;
            end
            if (d > WIN_LEN - 1) begin
                d = WIN_LEN - 1;
            end
            pix  = window[d[IDX_W-1:0]];
            coef = (k <= int'(tap_req.radius)) ? tap_coef(cfg, j) : '0;
            prod_next[t] = $signed({{(PROD_W-PIX_W){1'b0}}, pix})
                         * $signed({{(PROD_W-COEF_W){coef[COEF_W-1]}}, coef});
        end
    end

    always_comb begin
        sum_next = '0;
        for (int t = 0; t < WIN_LEN; t++) begin
            sum_next = sum_next + SUM_W'(prod_reg[t]);
        end
    end

    // shift down, clamp to the pixel range
    always_comb begin
        logic signed [SUM_W-1:0] shifted;
        shifted = sum_reg >>> COEF_FRAC_BITS;
        if (sum_reg <= 0) begin
            out_next = '0;
        end else if (shifted > $signed({{(SUM_W-PIX_W){1'b0}}, PIX_MAX})) begin
            out_next = PIX_MAX;
        end else begin
            out_next = shifted[PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (prod_rdy) begin
                prod_valid_reg <= tap_req.valid;
            end
            if (sum_rdy) begin
                sum_valid_reg <= prod_valid_reg;
            end
            if (out_rdy) begin
                out_valid_reg <= sum_valid_reg;
            end
        end
        if (prod_rdy) begin
            prod_reg       <= prod_next;
            prod_flags_reg <= tap_req.flags;
        end
        if (sum_rdy) begin
            sum_reg       <= sum_next;
            sum_flags_reg <= prod_flags_reg;
        end
        if (out_rdy) begin
            out_reg       <= out_next;
            out_flags_reg <= sum_flags_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_filtered   = out_reg;
    assign m_row_last   = out_flags_reg.row_last;
    assign m_burst_last = out_flags_reg.burst_last;

endmodule

FILE: rtl/row_fir_filter_clamp_core.sv
// path: a column goes from the window register through the product, sum and output registers to m_valid
// throughput: one pixel per cycle while m_ready stays high; a row-end pixel holds the window stage until it
//   has issued up to R+1 columns (fewer on a row shorter than R+1 pixels), one column each cycle
// every stage has its own valid so bubbles close up; m_ready reaches s_ready through the readies
// reset: aresetn synchronous, active low; clears the valid flags, the row position and the
//   registers to their defaults (centre tap 1.0, all side taps 0, radius 0)
`include "row_fir_filter_clamp_core_defines.svh"

module row_fir_filter_clamp_core #(
    parameter int MAX_RADIUS = rffc_pkg::DEFAULT_MAX_RADIUS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // pixel requests, raster order
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rffc_pkg::PIX_W-1:0]          s_pixel,
    input  logic                                s_row_end,
    // filtered results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rffc_pkg::PIX_W-1:0]          m_filtered,
    output logic                                m_row_last,
    output logic                                m_burst_last,
    // register writes, only while idle
    input  logic                                cfg_wr_en,
    input  logic [rffc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rffc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import rffc_pkg::*;

    cfg_t                          cfg;
    tap_req_t                      tap_req;
    logic                          tap_ready;
    logic [2*MAX_RADIUS:0][PIX_W-1:0] window;

    // coefficient and radius registers
    rffc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // input register: pixel window, row position and the column being issued
    // an ordinary pixel issues the column R back once R earlier pixels are in,
    // a row-end pixel issues the remaining columns oldest first
    rffc_window #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pixel    (s_pixel),
        .s_row_end  (s_row_end),
        .cfg_radius (cfg.radius),
        .tap_ready  (tap_ready),
        .tap_req    (tap_req),
        .window     (window)
    );

    // products, sum, then shift and clamp into the output register
    rffc_mac #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_mac (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .tap_req      (tap_req),
        .window       (window),
        .tap_ready    (tap_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_filtered   (m_filtered),
        .m_row_last   (m_row_last),
        .m_burst_last (m_burst_last)
    );

    // the row's final column is always the last result of its request
    `RFFC_ASSERT_NOW(a_row_last_ends_burst, m_valid && m_row_last, m_burst_last,
        "row_last without burst_last")
    // no new pixel is taken while a row flush still has columns to issue
    `RFFC_ASSERT_NOW(a_flush_blocks_input, tap_req.valid && !tap_req.flags.burst_last,
        !s_ready, "input taken during row flush")
    // a row-end pixel always leaves at least one column to issue
    `RFFC_ASSERT_NEXT(a_row_end_issues, s_valid && s_ready && s_row_end, tap_req.valid,
        "row end produced no column")

endmodule
